>>> rtl/three_axis_iir4_filter_assert.svh
// Assertion macros used by the filter RTL.
// Each use names a label, an antecedent and a consequent. The clock is clk and
// the checks are off while rst_n is low.
`ifndef THREE_AXIS_IIR4_FILTER_ASSERT_SVH
`define THREE_AXIS_IIR4_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define TAI4_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("three_axis_iir4_filter assertion failed");
// Next-cycle implication.
`define TAI4_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("three_axis_iir4_filter assertion failed");
`else
`define TAI4_ASSERT_NOW(lbl, ante, cons)
`define TAI4_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/tai4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tai4_pkg;

  localparam int AXES     = 3;
  localparam int TAPS     = 4;
  localparam int NPROD    = 2 * TAPS + 1;
  localparam int SAMPLE_W = 32;
  localparam int COEF_W   = 32;
  localparam int FRAC     = 28;
  localparam int ACC_W    = 68;
  localparam int RND_W    = ACC_W - FRAC;
  localparam int CNT_W    = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_B0_B1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B2_B3 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B4_A1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_A2_A3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_A4    = 3'd4;

  // 1.0 in Q4.28
  localparam logic [COEF_W-1:0] COEF_ONE = 32'h1000_0000;

  // half an output LSB at the accumulator scale
  localparam logic signed [ACC_W-1:0] RND_HALF =
    {{(ACC_W - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};

  typedef logic [COEF_W-1:0] coef_word_t;

  typedef struct packed {
    coef_word_t [TAPS:0] b;
    coef_word_t [TAPS:1] a;
  } coef_t;

  // coefficient set after reset: b0 = 1.0, everything else zero
  localparam coef_t COEF_RESET = '{b: {{TAPS{{COEF_W{1'b0}}}}, COEF_ONE}, a: '0};

  // per-request pipeline control shared by the lanes and the output stage
  typedef struct packed {
    logic cap;   // load a new request into the sample stage
    logic adv;   // move the sample stage into the product stage
    logic done;  // retire the product stage into the output register
    logic warm;  // the retiring request is a warm-up pass-through
  } lane_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/tai4_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module tai4_lane #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire                                       clk,
  input  wire                                       rst_n,
  input  tai4_pkg::coef_t                           coef_i,
  input  tai4_pkg::lane_ctrl_t                      ctrl_i,
  input  wire logic [tai4_pkg::SAMPLE_W-1:0]        sample_i,
  output logic signed [tai4_pkg::SAMPLE_W-1:0]      result_o,
  output logic                                      fallback_o
);

  localparam int SW  = (SAMPLE_WIDTH < tai4_pkg::SAMPLE_W) ? SAMPLE_WIDTH : tai4_pkg::SAMPLE_W;
  localparam int EXT = tai4_pkg::SAMPLE_W - SW;
  localparam int PW  = tai4_pkg::SAMPLE_W + tai4_pkg::COEF_W;

  logic signed [tai4_pkg::SAMPLE_W-1:0] s1_sample_r;
  logic signed [tai4_pkg::SAMPLE_W-1:0] s1_sample_nxt;
  logic signed [tai4_pkg::SAMPLE_W-1:0] s2_sample_r;
  logic signed [PW-1:0]                 prod_r   [tai4_pkg::NPROD];
  logic signed [PW-1:0]                 prod_nxt [tai4_pkg::NPROD];
  logic signed [tai4_pkg::SAMPLE_W-1:0] xh_r     [tai4_pkg::TAPS];
  logic signed [tai4_pkg::SAMPLE_W-1:0] yh_r     [tai4_pkg::TAPS];
  logic signed [tai4_pkg::ACC_W-1:0]    acc;
  logic        [tai4_pkg::RND_W-1:0]    rounded;
  logic                                 ovf;

  // keep the low SW bits, sign-extended
  assign s1_sample_nxt = $signed(sample_i << EXT) >>> EXT;

  always_ff @(posedge clk) begin
    if (ctrl_i.cap) begin
      s1_sample_r <= s1_sample_nxt;
    end
  end

  always_comb begin
    prod_nxt[0] = $signed(coef_i.b[0]) * s1_sample_r;
    for (int k = 1; k <= tai4_pkg::TAPS; k++) begin
      prod_nxt[k]                  = $signed(coef_i.b[k]) * xh_r[k-1];
      prod_nxt[tai4_pkg::TAPS + k] = $signed(coef_i.a[k]) * yh_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.adv) begin
      prod_r      <= prod_nxt;
      s2_sample_r <= s1_sample_r;
    end
  end

  always_comb begin
    acc = tai4_pkg::RND_HALF;
    for (int k = 0; k < tai4_pkg::NPROD; k++) begin
      if (k <= tai4_pkg::TAPS) begin
        acc = acc + tai4_pkg::ACC_W'(prod_r[k]);
      end else begin
        acc = acc - tai4_pkg::ACC_W'(prod_r[k]);
      end
    end
  end

  assign rounded = acc[tai4_pkg::ACC_W-1:tai4_pkg::FRAC];
  // result fits when every bit from the sample sign upward agrees
  assign ovf = !((&rounded[tai4_pkg::RND_W-1:SW-1]) || !(|rounded[tai4_pkg::RND_W-1:SW-1]));

  always_comb begin
    if (ctrl_i.warm || ovf) begin
      result_o = s2_sample_r;
    end else begin
      result_o = $signed(rounded[tai4_pkg::SAMPLE_W-1:0]);
    end
  end

  assign fallback_o = !ctrl_i.warm && ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < tai4_pkg::TAPS; k++) begin
        xh_r[k] <= '0;
        yh_r[k] <= '0;
      end
    end else if (ctrl_i.done) begin
      xh_r[0] <= s2_sample_r;
      yh_r[0] <= result_o;
      for (int k = 1; k < tai4_pkg::TAPS; k++) begin
        xh_r[k] <= xh_r[k-1];
        yh_r[k] <= yh_r[k-1];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/tai4_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module tai4_merge (
  input  wire                                                     clk,
  input  wire                                                     rst_n,
  input  tai4_pkg::lane_ctrl_t                                    ctrl_i,
  input  wire logic [tai4_pkg::AXES-1:0][tai4_pkg::SAMPLE_W-1:0]  result_i,
  input  wire logic [tai4_pkg::AXES-1:0]                          fallback_i,
  output logic                                                    free_o,
  output logic                                                    out_valid,
  input  wire                                                     out_stall,
  output logic signed [tai4_pkg::SAMPLE_W-1:0]                    out_x,
  output logic signed [tai4_pkg::SAMPLE_W-1:0]                    out_y,
  output logic signed [tai4_pkg::SAMPLE_W-1:0]                    out_z,
  output logic [tai4_pkg::AXES-1:0]                               out_fallback_mask,
  output logic                                                    out_warming_up
);

  logic                                              valid_r;
  logic                                              valid_nxt;
  logic [tai4_pkg::AXES-1:0][tai4_pkg::SAMPLE_W-1:0] res_r;
  logic [tai4_pkg::AXES-1:0]                         mask_r;
  logic                                              warm_r;

  assign free_o    = !valid_r || !out_stall;
  assign valid_nxt = ctrl_i.done ? 1'b1 : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.done) begin
      res_r  <= result_i;
      mask_r <= fallback_i;
      warm_r <= ctrl_i.warm;
    end
  end

  assign out_valid         = valid_r;
  assign out_x             = $signed(res_r[0]);
  assign out_y             = $signed(res_r[1]);
  assign out_z             = $signed(res_r[2]);
  assign out_fallback_mask = mask_r;
  assign out_warming_up    = warm_r;

endmodule

`default_nettype wire

>>> rtl/three_axis_iir4_filter.sv
// Channel   Direction  Handshake             Payload
// in_       request    in_valid / in_stall   in_sample_x, in_sample_y, in_sample_z
// out_      result     out_valid / out_stall out_x, out_y, out_z, out_fallback_mask,
//                                            out_warming_up
// cfg_      write      cfg_we                cfg_index, cfg_wdata
//
// A new request enters the sample stage as the one ahead moves on, then waits until
// the product stage is empty, as that stage multiplies the output history that the
// previous request writes on retire. Stages in order: sample, product, output.
// rst_n is synchronous: it clears histories, warm-up state, coefficients to b0 = 1.0
// and the pipeline valid bits. A stalled output holds the product stage and, behind
// it, the sample stage; a new request is still taken while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module three_axis_iir4_filter #(
  parameter int WARMUP_COUNT = 5,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire                                       clk,
  input  wire                                       rst_n,
  // request channel
  input  wire                                       in_valid,
  output logic                                      in_stall,
  input  wire logic signed [tai4_pkg::SAMPLE_W-1:0] in_sample_x,
  input  wire logic signed [tai4_pkg::SAMPLE_W-1:0] in_sample_y,
  input  wire logic signed [tai4_pkg::SAMPLE_W-1:0] in_sample_z,
  // result channel
  output logic                                      out_valid,
  input  wire                                       out_stall,
  output logic signed [tai4_pkg::SAMPLE_W-1:0]      out_x,
  output logic signed [tai4_pkg::SAMPLE_W-1:0]      out_y,
  output logic signed [tai4_pkg::SAMPLE_W-1:0]      out_z,
  output logic [tai4_pkg::AXES-1:0]                 out_fallback_mask,
  output logic                                      out_warming_up,
  // coefficient writes
  input  wire                                       cfg_we,
  input  wire logic [tai4_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [tai4_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  tai4_pkg::coef_t      coef_r;
  tai4_pkg::coef_t      coef_nxt;
  tai4_pkg::lane_ctrl_t ctrl;

  logic                                              accept;
  logic                                              out_free;
  logic                                              s1_valid_r;
  logic                                              s1_valid_nxt;
  logic                                              s1_warm_r;
  logic                                              s2_valid_r;
  logic                                              s2_valid_nxt;
  logic                                              s2_warm_r;
  logic                                              s1_adv;
  logic                                              s2_done;
  logic [tai4_pkg::CNT_W-1:0]                        warmup_cnt_r;
  logic [tai4_pkg::CNT_W-1:0]                        warmup_cnt_inc;
  logic                                              warmup_done_r;
  logic [tai4_pkg::AXES-1:0][tai4_pkg::SAMPLE_W-1:0] lane_sample;
  logic [tai4_pkg::AXES-1:0][tai4_pkg::SAMPLE_W-1:0] lane_result;
  logic [tai4_pkg::AXES-1:0]                         lane_fallback;

  // ---------------------------------------------------------------------------
  // Coefficient registers: each write splits the data into the packed words.
  // Indexes beyond the list are dropped.
  // ---------------------------------------------------------------------------
  always_comb begin
    coef_nxt = coef_r;
    if (cfg_we) begin
      case (cfg_index)
        tai4_pkg::CFG_B0_B1: begin
          coef_nxt.b[0] = cfg_wdata[63:32];
          coef_nxt.b[1] = cfg_wdata[31:0];
        end
        tai4_pkg::CFG_B2_B3: begin
          coef_nxt.b[2] = cfg_wdata[63:32];
          coef_nxt.b[3] = cfg_wdata[31:0];
        end
        tai4_pkg::CFG_B4_A1: begin
          coef_nxt.b[4] = cfg_wdata[63:32];
          coef_nxt.a[1] = cfg_wdata[31:0];
        end
        tai4_pkg::CFG_A2_A3: begin
          coef_nxt.a[2] = cfg_wdata[63:32];
          coef_nxt.a[3] = cfg_wdata[31:0];
        end
        tai4_pkg::CFG_A4: begin
          coef_nxt.a[4] = cfg_wdata[31:0];
        end
        default: begin
          coef_nxt = coef_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= tai4_pkg::COEF_RESET;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control.
  // Sample stage -> product stage only when the product stage is empty, so the
  // products always see the history left by the request ahead.
  // ---------------------------------------------------------------------------
  assign s1_adv   = s1_valid_r && !s2_valid_r;
  assign s2_done  = s2_valid_r && out_free;
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  assign s1_valid_nxt = accept ? 1'b1 : (s1_valid_r && !s1_adv);
  assign s2_valid_nxt = s1_adv ? 1'b1 : (s2_valid_r && !s2_done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // tag each request as warm-up at accept; requests stay in order
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_warm_r <= !warmup_done_r;
    end
    if (s1_adv) begin
      s2_warm_r <= s1_warm_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Warm-up counter: advance on every warm-up request, stop after WARMUP_COUNT.
  // ---------------------------------------------------------------------------
  assign warmup_cnt_inc = warmup_cnt_r + tai4_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warmup_cnt_r  <= '0;
      warmup_done_r <= 1'b0;
    end else if (accept && !warmup_done_r) begin
      if (warmup_cnt_inc >= tai4_pkg::CNT_W'(WARMUP_COUNT)) begin
        warmup_cnt_r  <= '0;
        warmup_done_r <= 1'b1;
      end else begin
        warmup_cnt_r <= warmup_cnt_inc;
      end
    end
  end

  always_comb begin
    ctrl.cap  = accept;
    ctrl.adv  = s1_adv;
    ctrl.done = s2_done;
    ctrl.warm = s2_warm_r;
  end

  // ---------------------------------------------------------------------------
  // One filter lane per axis; each lane keeps its own input and output history.
  // ---------------------------------------------------------------------------
  assign lane_sample[0] = in_sample_x;
  assign lane_sample[1] = in_sample_y;
  assign lane_sample[2] = in_sample_z;

  for (genvar ax = 0; ax < tai4_pkg::AXES; ax++) begin : g_lane
    tai4_lane #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .coef_i     (coef_r),
      .ctrl_i     (ctrl),
      .sample_i   (lane_sample[ax]),
      .result_o   (lane_result[ax]),
      .fallback_o (lane_fallback[ax])
    );
  end

  // combine the lane results into one output register
  tai4_merge u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl_i            (ctrl),
    .result_i          (lane_result),
    .fallback_i        (lane_fallback),
    .free_o            (out_free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_z             (out_z),
    .out_fallback_mask (out_fallback_mask),
    .out_warming_up    (out_warming_up)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
`include "three_axis_iir4_filter_assert.svh"

  // a request held behind a full output keeps its place and its warm-up tag
  `TAI4_ASSERT_NEXT(a_s2_hold, s2_valid_r && !out_free, s2_valid_r && $stable(s2_warm_r))
  // never take a request while both stages are occupied
  `TAI4_ASSERT_NOW(a_no_overrun, accept, !(s1_valid_r && s2_valid_r))
  // once warm-up is over, requests are filtered
  `TAI4_ASSERT_NEXT(a_warm_end, accept && warmup_done_r, !s1_warm_r)
  // the counter rests at zero after warm-up
  `TAI4_ASSERT_NOW(a_cnt_idle, warmup_done_r, warmup_cnt_r == '0)

endmodule

`default_nettype wire
